/* hw/rtl/rzo_pkg.sv */
package rzo_pkg;

  localparam int ZONE_COUNT_DEF = 3;
  localparam int MAX_POINTS_DEF = 8;

  localparam int CM_TO_MM   = 10;
  localparam int MIN_POINTS = 3;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Vertex coordinates after scaling to millimetres, edge deltas and products.
  localparam int SC_W   = 20;
  localparam int DIFF_W = SC_W + 1;
  localparam int PROD_W = 2 * DIFF_W;

  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_ZONE   = 2'd1;
  localparam logic [1:0] OP_TARGET = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         zone_index;
    logic [2:0]         vertex_index;
    logic signed [15:0] vertex_x_cm;
    logic signed [15:0] vertex_y_cm;
    logic [3:0]         zone_points;
    logic [15:0]        move_threshold;
    logic               target_present;
    logic signed [15:0] target_x_mm;
    logic signed [15:0] target_y_mm;
    logic signed [15:0] target_speed;
    logic               last_target;
  } in_t;

  typedef struct packed {
    logic [1:0] zone_id;
    logic [7:0] zone_target_count;
    logic       zone_presence;
    logic       zone_movement;
    logic       last_zone;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZONE,
    ST_RD_A,
    ST_RD_B,
    ST_MUL_L,
    ST_MUL_R,
    ST_EVAL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic en;
    logic sel;
  } edge_ctl_t;

  typedef struct packed {
    logic on_edge;
    logic crossing;
  } edge_res_t;

endpackage

/* hw/rtl/rzo_edge_unit.sv */
module rzo_edge_unit (
  input  logic                              clk_i,
  input  rzo_pkg::edge_ctl_t               ctl_i,
  input  logic signed [rzo_pkg::SC_W-1:0]   px_i,
  input  logic signed [rzo_pkg::SC_W-1:0]   py_i,
  input  logic signed [rzo_pkg::SC_W-1:0]   ax_i,
  input  logic signed [rzo_pkg::SC_W-1:0]   ay_i,
  input  logic signed [rzo_pkg::SC_W-1:0]   bx_i,
  input  logic signed [rzo_pkg::SC_W-1:0]   by_i,
  output rzo_pkg::edge_res_t                res_o
);
  import rzo_pkg::*;

  logic signed [DIFF_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] left_q, right_q;
  logic signed [PROD_W:0]   cross_val;
  logic                     cross_zero, cross_neg, in_box, straddle;

  // One multiplier serves both products of the edge test: the left product
  // (px-ax)*(by-ay) and the right product (bx-ax)*(py-ay).
  always_comb begin
    if (ctl_i.sel) begin
      op_a = DIFF_W'(bx_i) - DIFF_W'(ax_i);
      op_b = DIFF_W'(py_i) - DIFF_W'(ay_i);
    end else begin
      op_a = DIFF_W'(px_i) - DIFF_W'(ax_i);
      op_b = DIFF_W'(by_i) - DIFF_W'(ay_i);
    end
    prod = PROD_W'(op_a) * PROD_W'(op_b);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.sel) begin
        right_q <= prod;
      end else begin
        left_q <= prod;
      end
    end
  end

  // The cross product is left minus right, so its sign also orders the two.
  always_comb begin
    cross_val  = (PROD_W + 1)'(left_q) - (PROD_W + 1)'(right_q);
    cross_zero = (cross_val == '0);
    cross_neg  = cross_val[PROD_W];
    in_box     = ((px_i >= ax_i && px_i <= bx_i) || (px_i >= bx_i && px_i <= ax_i)) &&
                 ((py_i >= ay_i && py_i <= by_i) || (py_i >= by_i && py_i <= ay_i));
    straddle   = (ay_i > py_i) != (by_i > py_i);
    res_o.on_edge  = cross_zero && in_box;
    res_o.crossing = straddle &&
                     ((by_i > ay_i && cross_neg) ||
                      (by_i < ay_i && !cross_neg && !cross_zero));
  end

endmodule

/* hw/rtl/radar_zone_occupancy.sv */
// Radar zone occupancy counter.
// Items arrive on item_i and are taken at a rising edge where start_i is high
// and busy_o is low. Vertex loads and zone settings loads leave busy_o low.
// A radar target that is present keeps busy_o high while it is tested
// against every zone: a disabled zone is passed over in ST_ZONE, an enabled
// zone runs ST_ZONE and ST_RD_A and then ST_RD_B, ST_MUL_L, ST_MUL_R and
// ST_EVAL once per edge, stopping early when the target lies on an edge.
// Each edge needs two products from the single shared multiplier, a compare
// in ST_EVAL and one registered read of the vertex memory.
// On a frame's last target the block then puts out one result per zone, in
// zone order, each on result_o for exactly one cycle with result_valid_o
// high; the last one appears in the cycle in which busy_o drops. The receiver
// cannot stall, so nothing waits on it.
// Reset clears zone settings, hit counts and movement flags; vertex memory
// holds whatever it held until each vertex is loaded.
module radar_zone_occupancy #(
  parameter int ZONE_COUNT = rzo_pkg::ZONE_COUNT_DEF,
  parameter int MAX_POINTS = rzo_pkg::MAX_POINTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  rzo_pkg::in_t  item_i,
  output logic          result_valid_o,
  output rzo_pkg::out_t result_o
);
  import rzo_pkg::*;

  localparam int ZW    = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CW    = (PW > 4) ? PW : 4;
  localparam int DEPTH = ZONE_COUNT * MAX_POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic signed [SC_W-1:0] cm_to_mm(logic [15:0] v);
    logic signed [SC_W-1:0] e;
    e = SC_W'($signed(v));
    return e * SC_W'(CM_TO_MM);
  endfunction

  function automatic logic [AW-1:0] vaddr(logic [ZW-1:0] z, logic [PW-1:0] k);
    return AW'(z) * AW'(MAX_POINTS) + AW'(k);
  endfunction

  state_e state_q, state_d;

  logic [ZW-1:0] z_q;
  logic [PW-1:0] cur_q;
  logic          inside_q, last_q;

  logic signed [SC_W-1:0] px_q, py_q, ax_q, ay_q, bx_q, by_q;
  logic [16:0]            aspd_q;

  logic [3:0]  zone_pts_q [ZONE_COUNT];
  logic [15:0] zone_lim_q [ZONE_COUNT];
  logic [7:0]  hit_q      [ZONE_COUNT];
  logic        mov_q      [ZONE_COUNT];

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_q;
  logic          rd_en;
  logic [PW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;

  logic          accept;
  logic [3:0]    npts;
  logic          zone_en, zone_wrap, last_edge, zone_done, inside_next, zone_hit;
  logic [ZW-1:0] z_next;
  logic [16:0]   spd_ext;
  logic          latch_a, latch_b;
  edge_ctl_t     edge_ctl;
  edge_res_t     edge_res;
  out_t          res_q;
  logic          res_valid_q;

  assign accept = start_i && !busy_o;

  always_comb begin
    npts        = zone_pts_q[z_q];
    zone_en     = (npts >= 4'(MIN_POINTS)) && (6'(npts) <= 6'(MAX_POINTS));
    zone_wrap   = (z_q == ZW'(ZONE_COUNT - 1));
    z_next      = zone_wrap ? '0 : z_q + ZW'(1);
    last_edge   = (CW'(cur_q) == CW'(npts) - CW'(1));
    zone_done   = edge_res.on_edge || last_edge;
    inside_next = inside_q ^ edge_res.crossing;
    zone_hit    = edge_res.on_edge || (last_edge && inside_next);
    spd_ext     = {item_i.target_speed[15], item_i.target_speed};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && item_i.operation == OP_TARGET) begin
          if (item_i.target_present) begin
            state_d = ST_ZONE;
          end else if (item_i.last_target) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_ZONE: begin
        if (zone_en) begin
          state_d = ST_RD_A;
        end else if (zone_wrap) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_RD_A:  state_d = ST_RD_B;
      ST_RD_B:  state_d = ST_MUL_L;
      ST_MUL_L: state_d = ST_MUL_R;
      ST_MUL_R: state_d = ST_EVAL;
      ST_EVAL: begin
        if (!zone_done) begin
          state_d = ST_RD_B;
        end else if (!zone_wrap) begin
          state_d = ST_ZONE;
        end else begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (zone_wrap) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy_o       = 1'b1;
    rd_en        = 1'b0;
    rd_idx       = cur_q;
    latch_a      = 1'b0;
    latch_b      = 1'b0;
    edge_ctl.en  = 1'b0;
    edge_ctl.sel = 1'b0;
    case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_ZONE: begin
        // The first edge runs from the last vertex back to the first one.
        rd_en  = zone_en;
        rd_idx = PW'(npts - 4'd1);
      end
      ST_RD_A: begin
        latch_a = 1'b1;
        rd_en   = 1'b1;
        rd_idx  = cur_q;
      end
      ST_RD_B:  latch_b = 1'b1;
      ST_MUL_L: edge_ctl.en = 1'b1;
      ST_MUL_R: begin
        edge_ctl.en  = 1'b1;
        edge_ctl.sel = 1'b1;
      end
      ST_EVAL: begin
        rd_en  = !zone_done;
        rd_idx = cur_q + PW'(1);
      end
      ST_EMIT: busy_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  assign rd_addr = vaddr(z_q, rd_idx);

  always_ff @(posedge clk_i) begin
    if (accept && item_i.operation == OP_VERTEX &&
        32'(item_i.zone_index) < ZONE_COUNT && 32'(item_i.vertex_index) < MAX_POINTS) begin
      mem[vaddr(ZW'(item_i.zone_index), PW'(item_i.vertex_index))] <=
        {item_i.vertex_x_cm, item_i.vertex_y_cm};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.operation == OP_TARGET) begin
      px_q   <= SC_W'(item_i.target_x_mm);
      py_q   <= SC_W'(item_i.target_y_mm);
      aspd_q <= spd_ext[16] ? (~spd_ext + 17'd1) : spd_ext;
    end
    if (latch_a) begin
      ax_q <= cm_to_mm(rd_q[31:16]);
      ay_q <= cm_to_mm(rd_q[15:0]);
    end
    if (latch_b) begin
      bx_q <= cm_to_mm(rd_q[31:16]);
      by_q <= cm_to_mm(rd_q[15:0]);
    end else if (state_q == ST_EVAL) begin
      // The end of this edge starts the next one.
      ax_q <= bx_q;
      ay_q <= by_q;
    end
    if (state_q == ST_EMIT) begin
      res_q.zone_id           <= 2'(z_q);
      res_q.zone_target_count <= hit_q[z_q];
      res_q.zone_presence     <= (hit_q[z_q] != '0);
      res_q.zone_movement     <= mov_q[z_q];
      res_q.last_zone         <= zone_wrap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      z_q         <= '0;
      cur_q       <= '0;
      inside_q    <= 1'b0;
      last_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < ZONE_COUNT; i++) begin
        zone_pts_q[i] <= '0;
        zone_lim_q[i] <= '0;
        hit_q[i]      <= '0;
        mov_q[i]      <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_EMIT);
      case (state_q)
        ST_IDLE: begin
          if (accept && item_i.operation == OP_ZONE && 32'(item_i.zone_index) < ZONE_COUNT) begin
            zone_pts_q[ZW'(item_i.zone_index)] <= item_i.zone_points;
            zone_lim_q[ZW'(item_i.zone_index)] <= item_i.move_threshold;
          end
          if (accept && item_i.operation == OP_TARGET) begin
            last_q <= item_i.last_target;
            z_q    <= '0;
          end
        end
        ST_ZONE: begin
          inside_q <= 1'b0;
          cur_q    <= '0;
          if (!zone_en) begin
            z_q <= z_next;
          end
        end
        ST_EVAL: begin
          inside_q <= inside_next;
          if (zone_done) begin
            if (zone_hit) begin
              if (hit_q[z_q] != COUNT_MAX) begin
                hit_q[z_q] <= hit_q[z_q] + 8'd1;
              end
              if (aspd_q > 17'(zone_lim_q[z_q])) begin
                mov_q[z_q] <= 1'b1;
              end
            end
            z_q <= z_next;
          end else begin
            cur_q <= cur_q + PW'(1);
          end
        end
        ST_EMIT: begin
          hit_q[z_q] <= '0;
          mov_q[z_q] <= 1'b0;
          z_q        <= z_next;
        end
        default: begin
        end
      endcase
    end
  end

  rzo_edge_unit u_edge (
    .clk_i (clk_i),
    .ctl_i (edge_ctl),
    .px_i  (px_q),
    .py_i  (py_q),
    .ax_i  (ax_q),
    .ay_i  (ay_q),
    .bx_i  (bx_q),
    .by_i  (by_q),
    .res_o (edge_res)
  );

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_result_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == ST_EMIT)
    else $error("result strobe without an emit cycle");

  a_last_zone_ends_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_zone) |=> !result_valid_o)
    else $error("result after the last zone of a frame");

  a_products_in_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_L) |=> (state_q == ST_MUL_R))
    else $error("edge products out of sequence");

  a_read_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(rd_addr) < DEPTH))
    else $error("vertex read beyond the memory");

  a_busy_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> busy_o && !accept)
    else $error("transaction accepted while results are emitted");

endmodule
